[rtl/core/mlh_pkg.sv]
package mlh_pkg;

    // Widths of the frame-length division
    localparam int DivW = 26;
    localparam int QuoW = 11;

    // Frame length numerator for MPEG-2 and MPEG-2.5; MPEG-1 uses twice this
    localparam int HalfMult = 72000;

    // Version field codes in the header
    localparam logic [1:0] VBITS_MPEG25   = 2'd0;
    localparam logic [1:0] VBITS_RESERVED = 2'd1;
    localparam logic [1:0] VBITS_MPEG2    = 2'd2;
    localparam logic [1:0] VBITS_MPEG1    = 2'd3;

    // Reported version codes
    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam logic [1:0] LAYER_III    = 2'd1;
    localparam logic [3:0] BIDX_FREE    = 4'd0;
    localparam logic [3:0] BIDX_BAD     = 4'd15;
    localparam logic [1:0] SIDX_RESERVED = 2'd3;
    localparam logic [1:0] MODE_MONO    = 2'd3;

    localparam logic [10:0] SPF_MPEG1 = 11'd1152;
    localparam logic [10:0] SPF_LOWER = 11'd576;

    // Payload handed from cell to cell along the chain
    typedef struct packed {
        logic            ok;
        logic [1:0]      ver;
        logic [8:0]      kbps;
        logic [15:0]     fs;
        logic [10:0]     spf;
        logic            pad;
        logic [1:0]      ch;
        logic            crc;
        logic [DivW-1:0] rem;
        logic [QuoW-1:0] quo;
    } mlh_payload_t;

    typedef struct packed {
        logic         occ;
        mlh_payload_t pay;
    } mlh_token_t;

    // Bitrate in kbit/s for the given version and bitrate index
    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bidx);
        logic [8:0] hi;
        logic [8:0] lo;
        begin
            unique case (bidx)
                4'd1:    begin hi = 9'd32;  lo = 9'd8;   end
                4'd2:    begin hi = 9'd40;  lo = 9'd16;  end
                4'd3:    begin hi = 9'd48;  lo = 9'd24;  end
                4'd4:    begin hi = 9'd56;  lo = 9'd32;  end
                4'd5:    begin hi = 9'd64;  lo = 9'd40;  end
                4'd6:    begin hi = 9'd80;  lo = 9'd48;  end
                4'd7:    begin hi = 9'd96;  lo = 9'd56;  end
                4'd8:    begin hi = 9'd112; lo = 9'd64;  end
                4'd9:    begin hi = 9'd128; lo = 9'd80;  end
                4'd10:   begin hi = 9'd160; lo = 9'd96;  end
                4'd11:   begin hi = 9'd192; lo = 9'd112; end
                4'd12:   begin hi = 9'd224; lo = 9'd128; end
                4'd13:   begin hi = 9'd256; lo = 9'd144; end
                4'd14:   begin hi = 9'd320; lo = 9'd160; end
                default: begin hi = 9'd0;   lo = 9'd0;   end
            endcase
            return (ver == VER_MPEG1) ? hi : lo;
        end
    endfunction

    // Sampling rate in Hz for the given version and sample-rate index
    function automatic logic [15:0] fs_lookup(input logic [1:0] ver, input logic [1:0] sidx);
        logic [15:0] base;
        begin
            unique case (sidx)
                2'd0:    base = 16'd44100;
                2'd1:    base = 16'd48000;
                2'd2:    base = 16'd32000;
                default: base = 16'd0;
            endcase
            unique case (ver)
                VER_MPEG1: return base;
                VER_MPEG2: return base >> 1;
                default:   return base >> 2;
            endcase
        end
    endfunction

endpackage

[rtl/core/mpeg_layer3_header_decoder.sv]
// Layer III frame header decoder. One 32-bit candidate header (first stream byte
// in bits 31 to 24) is taken per transfer and gives one result: legality, version,
// bitrate, sample rate, samples per frame, frame length with padding, channel count
// and CRC presence; all fields other than valid_res read zero for an illegal header.
// A new header is accepted every cycle unless a finished result is waiting at a
// stalled output. The header is decoded and the numerator multiplied in the cycle
// it is offered, into a register loaded at the transfer edge. The 11 cells of the
// pipelined restoring divider that forms the frame length follow that register,
// the last cell being the output register. The whole chain holds while a
// finished result is stalled.
module mpeg_layer3_header_decoder
    import mlh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] header_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [1:0]  mpeg_version,
    output logic [8:0]  kbit_rate,
    output logic [15:0] sample_rate_hz,
    output logic [10:0] frame_samples,
    output logic [10:0] frame_bytes,
    output logic [1:0]  channel_count,
    output logic        has_crc
);

    logic       adv;
    logic       take;
    mlh_token_t chain [QuoW+1];
    mlh_token_t last;

    // The chain moves whenever the output register is empty or being taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    mlh_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .take        (take),
        .header_word (header_word),
        .tok         (chain[0])
    );

    // Divider cells, most significant quotient bit first
    for (genvar g = 0; g < QuoW; g++)
    begin : g_cell
        mlh_div_cell #(
            .Shift (QuoW - 1 - g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // Result fields from the last cell
    assign last           = chain[QuoW];
    assign out_valid      = last.occ;
    assign valid_res      = last.pay.ok;
    assign mpeg_version   = last.pay.ver;
    assign kbit_rate      = last.pay.kbps;
    assign sample_rate_hz = last.pay.fs;
    assign frame_samples  = last.pay.spf;
    assign frame_bytes    = last.pay.quo + QuoW'(last.pay.pad);
    assign channel_count  = last.pay.ch;
    assign has_crc        = last.pay.crc;

endmodule

[rtl/core/mlh_decode.sv]
module mlh_decode
    import mlh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        take,
    input  logic [31:0] header_word,
    output mlh_token_t  tok
);

    logic         occ_reg;
    mlh_payload_t pay_reg;
    mlh_payload_t pay_next;

    logic [1:0]      vbits;
    logic [1:0]      lbits;
    logic [3:0]      bidx;
    logic [1:0]      sidx;
    logic            legal;
    logic [1:0]      ver;
    logic [8:0]      kbps;
    logic [DivW-1:0] prod;

    // Header field extraction and legality test
    assign vbits = header_word[20:19];
    assign lbits = header_word[18:17];
    assign bidx  = header_word[15:12];
    assign sidx  = header_word[11:10];
    assign legal = (header_word[31:21] == 11'h7FF) && (vbits != VBITS_RESERVED) &&
                   (lbits == LAYER_III) && (bidx != BIDX_FREE) && (bidx != BIDX_BAD) &&
                   (sidx != SIDX_RESERVED);

    // Table lookups and the numerator of the frame-length division
    always_comb
    begin
        unique case (vbits)
            VBITS_MPEG1: ver = VER_MPEG1;
            VBITS_MPEG2: ver = VER_MPEG2;
            default:     ver = VER_MPEG25;
        endcase
        kbps = kbps_lookup(ver, bidx);
        prod = DivW'(HalfMult) * DivW'(kbps);
        if (ver == VER_MPEG1)
        begin
            prod = prod << 1;
        end

        pay_next = '0;
        if (legal)
        begin
            pay_next.ok   = 1'b1;
            pay_next.ver  = ver;
            pay_next.kbps = kbps;
            pay_next.fs   = fs_lookup(ver, sidx);
            pay_next.spf  = (ver == VER_MPEG1) ? SPF_MPEG1 : SPF_LOWER;
            pay_next.pad  = header_word[9];
            pay_next.ch   = (header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
            pay_next.crc  = ~header_word[16];
            pay_next.rem  = prod;
        end
    end

    // Occupancy bit is control state; the payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (adv)
        begin
            occ_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg <= pay_next;
        end
    end

    assign tok.occ = occ_reg;
    assign tok.pay = pay_reg;

endmodule

[rtl/core/mlh_div_cell.sv]
module mlh_div_cell
    import mlh_pkg::*;
#(
    parameter int Shift = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  mlh_token_t tok_in,
    output mlh_token_t tok_out
);

    logic            occ_reg;
    mlh_payload_t    pay_reg;
    mlh_payload_t    pay_next;
    logic [DivW-1:0] trial;

    // One restoring division step: settles quotient bit Shift
    always_comb
    begin
        trial    = DivW'(tok_in.pay.fs) << Shift;
        pay_next = tok_in.pay;
        if (tok_in.pay.ok && (tok_in.pay.rem >= trial))
        begin
            pay_next.rem        = tok_in.pay.rem - trial;
            pay_next.quo[Shift] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (adv)
        begin
            occ_reg <= tok_in.occ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg <= pay_next;
        end
    end

    assign tok_out.occ = occ_reg;
    assign tok_out.pay = pay_reg;

endmodule

[tb/sv/mpeg_layer3_header_checker.sv]
`timescale 1ns / 1ps

module mpeg_layer3_header_checker
    import mlh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] header_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        valid_res,
    input  logic [1:0]  mpeg_version,
    input  logic [8:0]  kbit_rate,
    input  logic [15:0] sample_rate_hz,
    input  logic [10:0] frame_samples,
    input  logic [10:0] frame_bytes,
    input  logic [1:0]  channel_count,
    input  logic        has_crc,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          legal_count
);

    // One decoded header as the block should report it.
    typedef struct packed {
        logic        legal;
        logic [1:0]  version;
        logic [8:0]  kbps;
        logic [15:0] rate_hz;
        logic [10:0] spf;
        logic [10:0] length;
        logic [1:0]  channels;
        logic        crc;
    } frame_info_t;

    frame_info_t frame_info_q [$];
    frame_info_t want;
    int          mismatches = 0;
    int          results = 0;
    int          legals = 0;

    // Bitrate in kbit/s; the lower sampling families share one table.
    function automatic logic [8:0] bitrate_for(input logic lsf, input logic [3:0] idx);
        logic [8:0] kbps;
        begin
            case (idx)
                4'd1:    kbps = lsf ? 9'd8   : 9'd32;
                4'd2:    kbps = lsf ? 9'd16  : 9'd40;
                4'd3:    kbps = lsf ? 9'd24  : 9'd48;
                4'd4:    kbps = lsf ? 9'd32  : 9'd56;
                4'd5:    kbps = lsf ? 9'd40  : 9'd64;
                4'd6:    kbps = lsf ? 9'd48  : 9'd80;
                4'd7:    kbps = lsf ? 9'd56  : 9'd96;
                4'd8:    kbps = lsf ? 9'd64  : 9'd112;
                4'd9:    kbps = lsf ? 9'd80  : 9'd128;
                4'd10:   kbps = lsf ? 9'd96  : 9'd160;
                4'd11:   kbps = lsf ? 9'd112 : 9'd192;
                4'd12:   kbps = lsf ? 9'd128 : 9'd224;
                4'd13:   kbps = lsf ? 9'd144 : 9'd256;
                4'd14:   kbps = lsf ? 9'd160 : 9'd320;
                default: kbps = 9'd0;
            endcase
            return kbps;
        end
    endfunction

    // Sampling rate in Hz for each reported version and rate index.
    function automatic logic [15:0] sample_rate_for(input logic [1:0] ver,
                                                    input logic [1:0] idx);
        logic [15:0] hz;
        begin
            case ({ver, idx})
                {VER_MPEG1, 2'd0}:  hz = 16'd44100;
                {VER_MPEG1, 2'd1}:  hz = 16'd48000;
                {VER_MPEG1, 2'd2}:  hz = 16'd32000;
                {VER_MPEG2, 2'd0}:  hz = 16'd22050;
                {VER_MPEG2, 2'd1}:  hz = 16'd24000;
                {VER_MPEG2, 2'd2}:  hz = 16'd16000;
                {VER_MPEG25, 2'd0}: hz = 16'd11025;
                {VER_MPEG25, 2'd1}: hz = 16'd12000;
                {VER_MPEG25, 2'd2}: hz = 16'd8000;
                default:            hz = 16'd0;
            endcase
            return hz;
        end
    endfunction

    // Works out the full result for one candidate header.
    function automatic frame_info_t decode_header(input logic [31:0] w);
        frame_info_t info;
        logic [1:0]  vbits;
        logic [3:0]  bidx;
        logic [1:0]  sidx;
        logic        lsf;
        int unsigned numerator;
        int unsigned len;
        begin
            info  = '0;
            vbits = w[20:19];
            bidx  = w[15:12];
            sidx  = w[11:10];
            if (w[31:21] == 11'h7FF && vbits != VBITS_RESERVED && w[18:17] == LAYER_III &&
                bidx != BIDX_FREE && bidx != BIDX_BAD && sidx != SIDX_RESERVED)
            begin
                info.legal = 1'b1;
                case (vbits)
                    VBITS_MPEG1: info.version = VER_MPEG1;
                    VBITS_MPEG2: info.version = VER_MPEG2;
                    default:     info.version = VER_MPEG25;
                endcase
                lsf          = (info.version != VER_MPEG1);
                info.kbps    = bitrate_for(lsf, bidx);
                info.rate_hz = sample_rate_for(info.version, sidx);
                info.spf     = lsf ? SPF_LOWER : SPF_MPEG1;
                numerator    = lsf ? HalfMult : 2 * HalfMult;
                // The quotient truncates; the padding bit adds one byte.
                len          = numerator * info.kbps / info.rate_hz + w[9];
                info.length  = 11'(len);
                info.channels = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
                info.crc     = ~w[16];
            end
            return info;
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        begin
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        end
    endtask

    // Results are retired before new headers are queued, so a result can
    // never be matched against a header taken in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results++;
                if (valid_res === 1'b1)
                    legals++;
                if (frame_info_q.size() == 0)
                begin
                    $error("result transfer with no header outstanding");
                    mismatches++;
                end
                else
                begin
                    want = frame_info_q.pop_front();
                    check_field("valid_res", 16'(want.legal), 16'(valid_res));
                    check_field("mpeg_version", 16'(want.version), 16'(mpeg_version));
                    check_field("kbit_rate", 16'(want.kbps), 16'(kbit_rate));
                    check_field("sample_rate_hz", want.rate_hz, sample_rate_hz);
                    check_field("frame_samples", 16'(want.spf), 16'(frame_samples));
                    check_field("frame_bytes", 16'(want.length), 16'(frame_bytes));
                    check_field("channel_count", 16'(want.channels), 16'(channel_count));
                    check_field("has_crc", 16'(want.crc), 16'(has_crc));
                end
            end
            if (in_valid && !in_stall)
                frame_info_q.insert(frame_info_q.size(), decode_header(header_word));
        end
        fail_count   <= mismatches;
        pending      <= frame_info_q.size();
        result_count <= results;
        legal_count  <= legals;
    end

endmodule

[tb/sv/mpeg_layer3_header_decoder_tb.sv]
`timescale 1ns / 1ps

module mpeg_layer3_header_decoder_tb
    import mlh_pkg::*;
();

    localparam int RandomHeaders = 600;
    localparam int CalmTail      = 50;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 24;

    // Channel modes other than mono
    localparam logic [1:0] MODE_STEREO = 2'd0;
    localparam logic [1:0] MODE_JOINT  = 2'd1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] header_word;
    logic        out_valid;
    logic        out_stall;
    logic        valid_res;
    logic [1:0]  mpeg_version;
    logic [8:0]  kbit_rate;
    logic [15:0] sample_rate_hz;
    logic [10:0] frame_samples;
    logic [10:0] frame_bytes;
    logic [1:0]  channel_count;
    logic        has_crc;
    logic        bursts_on;
    int          fail_count;
    int          pending;
    int          result_count;
    int          legal_count;
    int          quiet_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mpeg_layer3_header_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .header_word    (header_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .valid_res      (valid_res),
        .mpeg_version   (mpeg_version),
        .kbit_rate      (kbit_rate),
        .sample_rate_hz (sample_rate_hz),
        .frame_samples  (frame_samples),
        .frame_bytes    (frame_bytes),
        .channel_count  (channel_count),
        .has_crc        (has_crc)
    );

    mpeg_layer3_header_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .header_word    (header_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .valid_res      (valid_res),
        .mpeg_version   (mpeg_version),
        .kbit_rate      (kbit_rate),
        .sample_rate_hz (sample_rate_hz),
        .frame_samples  (frame_samples),
        .frame_bytes    (frame_bytes),
        .channel_count  (channel_count),
        .has_crc        (has_crc),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .legal_count    (legal_count)
    );

    // Builds a header with good sync; the bits no result depends on are random.
    function automatic logic [31:0] mk_header(input logic [1:0] vbits, input logic [1:0] layer,
                                              input logic [3:0] bidx, input logic [1:0] sidx,
                                              input logic pad, input logic prot,
                                              input logic [1:0] mode);
        logic [31:0] w;
        begin
            w        = $urandom;
            w[31:21] = 11'h7FF;
            w[20:19] = vbits;
            w[18:17] = layer;
            w[16]    = prot;
            w[15:12] = bidx;
            w[11:10] = sidx;
            w[9]     = pad;
            w[7:6]   = mode;
            return w;
        end
    endfunction

    // Mostly legal headers with random content, then broken ones and noise.
    function automatic logic [31:0] random_header();
        logic [31:0] w;
        logic [1:0]  vbits;
        int          pick;
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       vbits = VBITS_MPEG1;
                1:       vbits = VBITS_MPEG2;
                default: vbits = VBITS_MPEG25;
            endcase
            w = mk_header(vbits, LAYER_III, 4'($urandom_range(1, 14)),
                          2'($urandom_range(0, 2)), 1'($urandom), 1'($urandom),
                          2'($urandom));
            if (pick >= 88)
                w = $urandom;
            else if (pick >= 70)
            begin
                // Break exactly one condition of legality.
                case ($urandom_range(0, 5))
                    0:       w[31:24] = w[31:24] ^ 8'($urandom_range(1, 255));
                    1:       w[23:21] = w[23:21] ^ 3'($urandom_range(1, 7));
                    2:       w[20:19] = VBITS_RESERVED;
                    3:       w[18:17] = LAYER_III ^ 2'($urandom_range(1, 3));
                    4:       w[15:12] = $urandom_range(0, 1) ? BIDX_FREE : BIDX_BAD;
                    default: w[11:10] = SIDX_RESERVED;
                endcase
            end
            return w;
        end
    endfunction

    // Offers one header and returns at the edge where the transfer happens.
    task automatic send_header(input logic [31:0] word);
        begin
            if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            in_valid    <= 1'b1;
            header_word <= word;
            do @(posedge clk); while (in_stall);
        end
    endtask

    // Lets every outstanding result out before the next header is offered.
    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
        end
    endtask

    // Receiver stalls in random bursts while bursts are enabled.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("mpeg_layer3_header_decoder_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] w;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        header_word <= '0;
        bursts_on   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes: all zeros and all ones.
        send_header(32'h0000_0000);
        send_header(32'hFFFF_FFFF);

        // Longest and shortest frames, and the truncating division.
        send_header(mk_header(VBITS_MPEG1, LAYER_III, 4'd14, 2'd2, 1'b1, 1'b0, MODE_STEREO));
        send_header(mk_header(VBITS_MPEG2, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b1, MODE_MONO));
        send_header(mk_header(VBITS_MPEG25, LAYER_III, 4'd14, 2'd2, 1'b1, 1'b0, MODE_JOINT));
        send_header(mk_header(VBITS_MPEG25, LAYER_III, 4'd1, 2'd1, 1'b0, 1'b1, MODE_STEREO));
        send_header(mk_header(VBITS_MPEG1, LAYER_III, 4'd1, 2'd0, 1'b1, 1'b1, MODE_JOINT));
        send_header(mk_header(VBITS_MPEG2, LAYER_III, 4'd13, 2'd0, 1'b0, 1'b0, MODE_MONO));

        // Each rejection on its own: reserved version, other layers, free and bad
        // bitrate, reserved sample rate, and broken sync in either byte.
        send_header(mk_header(VBITS_RESERVED, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, MODE_STEREO));
        for (int k = 1; k < 4; k++)
            send_header(mk_header(VBITS_MPEG1, LAYER_III ^ 2'(k), 4'd9, 2'd0, 1'b0, 1'b1,
                                  MODE_STEREO));
        send_header(mk_header(VBITS_MPEG1, LAYER_III, BIDX_FREE, 2'd1, 1'b0, 1'b1, MODE_MONO));
        send_header(mk_header(VBITS_MPEG2, LAYER_III, BIDX_BAD, 2'd1, 1'b1, 1'b0, MODE_MONO));
        send_header(mk_header(VBITS_MPEG25, LAYER_III, 4'd5, SIDX_RESERVED, 1'b0, 1'b1,
                              MODE_STEREO));
        w     = mk_header(VBITS_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, MODE_STEREO);
        w[24] = 1'b0;
        send_header(w);
        w     = mk_header(VBITS_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1, MODE_STEREO);
        w[21] = 1'b0;
        send_header(w);

        // Every channel mode, with and without CRC.
        for (int m = 0; m < 4; m++)
            send_header(mk_header(VBITS_MPEG1, LAYER_III, 4'd9, 2'd1, 1'(m), 1'(m >> 1), 2'(m)));

        drain_results();

        // Random headers; idle and stall bursts switch on and off in stretches and stop for the tail.
        for (int n = 0; n < RandomHeaders; n++)
        begin
            if (n % 50 == 0)
                bursts_on <= (n < RandomHeaders - CalmTail) && ($urandom_range(0, 3) != 0);
            if (n == RandomHeaders / 2)
                drain_results();
            send_header(random_header());
        end

        drain_results();
        repeat (DrainCycles) @(posedge clk);

        $display("Checked %0d results (%0d legal headers) over directed edge cases and",
                 result_count, legal_count);
        $display("random legal, broken and noise headers with idle and stall bursts.");
        if (fail_count == 0)
            $display("mpeg_layer3_header_decoder_tb: done, clean");
        else
            $display("mpeg_layer3_header_decoder_tb: done, errors");
        $finish;
    end

endmodule
